// ===== rtl/utf8_to_bmp_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 to BMP decoder assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_BMP_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_BMP_DECODER_UNIT_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define U2B_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define U2B_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `U2B_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/u2b_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to BMP decoder package
// Byte classes, decoder phases, status codes and the item and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u2b_pkg;

  // Class of one raw byte, decided in the front part.
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,  // 0x00-0x7F
    CLS_CONT  = 3'd1,  // 0x80-0xBF
    CLS_LEAD2 = 3'd2,  // 0xC0-0xDF
    CLS_LEAD3 = 3'd3,  // 0xE0-0xEF
    CLS_BAD   = 3'd4   // 0xF0-0xFF
  } byte_cls_e;

  // Decoder phase held in the back part.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TWO_2   = 3'd1,
    PH_THREE_2 = 3'd2,
    PH_THREE_3 = 3'd3,
    PH_DISCARD = 3'd4
  } phase_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEAD  = 2'd1,
    ST_CONT  = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned PartialW = 10;
  localparam int unsigned ContW    = 6;

  // One classified byte as it travels through the middle queue.
  typedef struct packed {
    byte_cls_e          cls;
    logic [ByteW-1:0]   data;
    logic               last;
  } item_t;

  // One decoded result as it waits in the output queue.
  typedef struct packed {
    logic [CodeW-1:0]   code_point;
    status_e            status;
    logic               ends_string;
  } result_t;

endpackage : u2b_pkg

`default_nettype wire

// ===== rtl/u2b_fifo.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to BMP decoder queue
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2b_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // A transfer happens only where the flags allow it.
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  // Pointer wrap and occupancy update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset: an entry is read only after it was written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule : u2b_fifo

`default_nettype wire

// ===== rtl/u2b_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to BMP decoder front part
// Classifies each incoming byte by its leading bits before it is queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2b_front
  import u2b_pkg::*;
(
  input  wire logic [ByteW-1:0] input_byte_i,
  input  wire logic             string_end_i,
  output item_t                 item_o
);

  byte_cls_e cls;

  // The top bits alone decide the class of a byte.
  always_comb begin
    priority casez (input_byte_i[7:4])
      4'b0???: cls = CLS_ASCII;
      4'b10??: cls = CLS_CONT;
      4'b110?: cls = CLS_LEAD2;
      4'b1110: cls = CLS_LEAD3;
      default: cls = CLS_BAD;
    endcase
  end

  assign item_o.cls  = cls;
  assign item_o.data = input_byte_i;
  assign item_o.last = string_end_i;

endmodule : u2b_front

`default_nettype wire

// ===== rtl/u2b_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to BMP decoder back part
// Runs the sequence state machine on classified bytes and forms the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2b_back
  import u2b_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_empty_i,
  input  wire item_t in_item_i,
  output logic       in_pop_o,
  input  wire logic  out_full_i,
  output logic       out_push_o,
  output result_t    out_result_o
);

  phase_e                phase_q, phase_d;
  logic [PartialW-1:0]   partial_q, partial_d;
  logic                  step;
  logic                  emit;
  logic [ContW-1:0]      cont_bits;
  logic                  is_cont;

  // A byte is taken only when the output queue has room, whether or not it yields a result.
  assign step      = !in_empty_i && !out_full_i;
  assign in_pop_o  = step;
  assign out_push_o = step && emit;

  assign cont_bits = in_item_i.data[ContW-1:0];
  assign is_cont   = (in_item_i.cls == CLS_CONT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      partial_q <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
    end
  end

  // Next phase, gathered bits and result for the byte at the queue head.
  always_comb begin
    phase_d      = phase_q;
    partial_d    = partial_q;
    emit         = 1'b0;
    out_result_o = '{code_point: '0, status: ST_OK, ends_string: 1'b1};
    unique case (phase_q)
      PH_IDLE: begin
        unique case (in_item_i.cls)
          CLS_ASCII: begin
            emit         = 1'b1;
            out_result_o = '{code_point: CodeW'(in_item_i.data), status: ST_OK,
                             ends_string: in_item_i.last};
          end
          CLS_LEAD2, CLS_LEAD3: begin
            if (in_item_i.last) begin
              emit                = 1'b1;
              out_result_o.status = ST_TRUNC;
              partial_d           = '0;
            end else if (in_item_i.cls == CLS_LEAD2) begin
              partial_d = PartialW'(in_item_i.data[4:0]);
              phase_d   = PH_TWO_2;
            end else begin
              partial_d = PartialW'(in_item_i.data[3:0]);
              phase_d   = PH_THREE_2;
            end
          end
          default: begin
            emit                = 1'b1;
            out_result_o.status = ST_LEAD;
            partial_d           = '0;
            phase_d             = in_item_i.last ? PH_IDLE : PH_DISCARD;
          end
        endcase
      end
      PH_TWO_2, PH_THREE_3: begin
        emit      = 1'b1;
        partial_d = '0;
        if (!is_cont) begin
          out_result_o.status = ST_CONT;
          phase_d             = in_item_i.last ? PH_IDLE : PH_DISCARD;
        end else begin
          phase_d      = PH_IDLE;
          out_result_o = '{code_point: {partial_q, cont_bits}, status: ST_OK,
                           ends_string: in_item_i.last};
        end
      end
      PH_THREE_2: begin
        if (!is_cont) begin
          emit                = 1'b1;
          out_result_o.status = ST_CONT;
          partial_d           = '0;
          phase_d             = in_item_i.last ? PH_IDLE : PH_DISCARD;
        end else if (in_item_i.last) begin
          emit                = 1'b1;
          out_result_o.status = ST_TRUNC;
          partial_d           = '0;
          phase_d             = PH_IDLE;
        end else begin
          partial_d = {partial_q[3:0], cont_bits};
          phase_d   = PH_THREE_3;
        end
      end
      default: begin
        // Discarding up to the end of the string, unused codes included.
        if (in_item_i.last) begin
          phase_d   = PH_IDLE;
          partial_d = '0;
        end
      end
    endcase
  end

endmodule : u2b_back

`default_nettype wire

// ===== rtl/utf8_to_bmp_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to BMP decoder unit
// Decodes a UTF-8 byte stream into 16-bit code points with error reporting.
// ----------------------------------------------------------------------------
// Channel  | Handshake         | Payload
// bytes    | push, full        | input_byte_i[7:0], string_end_i
// results  | pop, empty        | code_point_o[15:0], status_o[1:0], ends_string_o
//
// One byte is taken every cycle while full is low; the decode step is one state update per byte.
// A byte passes the middle queue and then the output queue before its result is
// on the result ports, where it can be taken while empty is low.
// Reset clears both queues and returns the decoder to the idle phase.
// full rises when the middle queue holds MidDepth bytes; for MidDepth above one this needs the back
// part to have been blocked by a full output queue, so only after pop was low.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_to_bmp_decoder_unit_assert.svh"

module utf8_to_bmp_decoder_unit
  import u2b_pkg::*;
#(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [ByteW-1:0]  input_byte_i,
  input  wire logic              string_end_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [CodeW-1:0]       code_point_o,
  output logic [1:0]             status_o,
  output logic                   ends_string_o
);

  item_t   front_item, mid_item;
  logic    mid_empty, mid_pop;
  logic    out_full, out_push;
  result_t back_result, out_result;

  // Front part: classify the incoming byte.
  u2b_front u_front (
    .input_byte_i (input_byte_i),
    .string_end_i (string_end_i),
    .item_o       (front_item)
  );

  // Queue between the front and the back part.
  u2b_fifo #(
    .Width ($bits(item_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  // Back part: sequence decoding.
  u2b_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_empty_i   (mid_empty),
    .in_item_i    (mid_item),
    .in_pop_o     (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_result_o (back_result)
  );

  // Output queue holding finished results.
  u2b_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_result),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_result),
    .empty_o (empty)
  );

  assign code_point_o  = out_result.code_point;
  assign status_o      = out_result.status;
  assign ends_string_o = out_result.ends_string;

  // Error results carry a zero code point and always close the string.
  `U2B_ASSERT(a_err_result, clk_i, rst_ni, (!empty && status_o != ST_OK) |-> (ends_string_o && code_point_o == '0), "error result malformed")
  // The back part must never write a result into a full output queue.
  `U2B_ASSERT_NEVER(a_out_overflow, clk_i, rst_ni, out_push && out_full, "output queue overflow")
  // The back part must only take bytes that are present.
  `U2B_ASSERT_NEVER(a_mid_underflow, clk_i, rst_ni, mid_pop && mid_empty, "middle queue underflow")

endmodule : utf8_to_bmp_decoder_unit

`default_nettype wire
